// File: src/cop_pkg.sv
// ----------------------------------------------------------------------------
// cop_pkg
// Shared widths and bundle types for the circle overlap push-out pipeline.
// ----------------------------------------------------------------------------
package cop_pkg;

  localparam int unsigned CoordW  = 32;                 // Q16.16 coordinate
  localparam int unsigned RadW    = 31;                 // Q15.16 local radius
  localparam int unsigned ScaleW  = 16;                 // Q8.8 scale
  localparam int unsigned SsumW   = ScaleW + 1;         // sum of two scales
  localparam int unsigned MeanSh  = 9;                  // /2 mean, /256 Q8.8
  localparam int unsigned WprodW  = RadW + SsumW;       // 48
  localparam int unsigned WradW   = WprodW - MeanSh;    // 39
  localparam int unsigned RsumW   = WradW + 1;          // 40
  localparam int unsigned DiffW   = CoordW + 1;         // 33
  localparam int unsigned SqW     = 2 * DiffW;          // 66
  localparam int unsigned DistW   = SqW / 2;            // 33
  localparam int unsigned OvlLoW  = RsumW / 2;          // 20
  localparam int unsigned OvlHiW  = RsumW - OvlLoW;     // 20
  localparam int unsigned PartW   = DiffW + OvlLoW;     // 53
  localparam int unsigned QuoW    = RsumW;              // push magnitude
  localparam int unsigned NumW    = DistW + QuoW;       // 73

  typedef struct packed {
    logic                     opcode;
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic        [RadW-1:0]   a_radius;
    logic        [RadW-1:0]   b_radius;
    logic        [ScaleW-1:0] a_scale_x;
    logic        [ScaleW-1:0] a_scale_y;
    logic        [ScaleW-1:0] b_scale_x;
    logic        [ScaleW-1:0] b_scale_y;
  } cop_in_t;

  // Travels beside the square root.
  typedef struct packed {
    logic                     push_req;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic                     neg_x;
    logic                     neg_y;
    logic        [DiffW-1:0]  mag_x;
    logic        [DiffW-1:0]  mag_y;
    logic        [RsumW-1:0]  rsum;
  } cop_sq_sb_t;

  // Travels beside the divider.
  typedef struct packed {
    logic                     push;
    logic                     hit;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic                     neg_x;
    logic                     neg_y;
  } cop_dv_sb_t;

endpackage

// File: src/cop_front.sv
// ----------------------------------------------------------------------------
// cop_front
// Four-stage front end: deltas, world radii, squares, sum of squares.
// ----------------------------------------------------------------------------
module cop_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  cop_pkg::cop_in_t    word_i,
  output logic                vld_o,
  output logic [cop_pkg::SqW-1:0] n_o,
  output cop_pkg::cop_sq_sb_t sb_o
);
  import cop_pkg::*;

  logic [3:0] vld_q;

  // stage 1
  logic                     s1_op_q;
  logic signed [CoordW-1:0] s1_bx_q, s1_by_q;
  logic signed [DiffW-1:0]  s1_dx_q, s1_dy_q;
  logic [RadW-1:0]          s1_ra_q, s1_rb_q;
  logic [SsumW-1:0]         s1_sa_q, s1_sb_q;
  // stage 2
  logic                     s2_op_q;
  logic signed [CoordW-1:0] s2_bx_q, s2_by_q;
  logic                     s2_nx_q, s2_ny_q;
  logic [DiffW-1:0]         s2_mx_q, s2_my_q;
  logic [WradW-1:0]         s2_wa_q, s2_wb_q;
  logic [WprodW-1:0]        wa_p, wb_p;
  // stage 3
  cop_sq_sb_t               s3_sb_q;
  logic [SqW-1:0]           s3_sqx_q, s3_sqy_q;
  // stage 4
  cop_sq_sb_t               s4_sb_q;
  logic [SqW-1:0]           s4_n_q;

  assign wa_p = WprodW'(s1_ra_q) * WprodW'(s1_sa_q);
  assign wb_p = WprodW'(s1_rb_q) * WprodW'(s1_sb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_op_q <= word_i.opcode;
      s1_bx_q <= word_i.b_x;
      s1_by_q <= word_i.b_y;
      s1_dx_q <= DiffW'(word_i.b_x) - DiffW'(word_i.a_x);
      s1_dy_q <= DiffW'(word_i.b_y) - DiffW'(word_i.a_y);
      s1_ra_q <= word_i.a_radius;
      s1_rb_q <= word_i.b_radius;
      s1_sa_q <= SsumW'(word_i.a_scale_x) + SsumW'(word_i.a_scale_y);
      s1_sb_q <= SsumW'(word_i.b_scale_x) + SsumW'(word_i.b_scale_y);

      s2_op_q <= s1_op_q;
      s2_bx_q <= s1_bx_q;
      s2_by_q <= s1_by_q;
      s2_nx_q <= s1_dx_q[DiffW-1];
      s2_ny_q <= s1_dy_q[DiffW-1];
      s2_mx_q <= s1_dx_q[DiffW-1] ? DiffW'(-s1_dx_q) : DiffW'(s1_dx_q);
      s2_my_q <= s1_dy_q[DiffW-1] ? DiffW'(-s1_dy_q) : DiffW'(s1_dy_q);
      s2_wa_q <= wa_p[WprodW-1:MeanSh];
      s2_wb_q <= wb_p[WprodW-1:MeanSh];

      s3_sb_q.push_req <= s2_op_q;
      s3_sb_q.b_x      <= s2_bx_q;
      s3_sb_q.b_y      <= s2_by_q;
      s3_sb_q.neg_x    <= s2_nx_q;
      s3_sb_q.neg_y    <= s2_ny_q;
      s3_sb_q.mag_x    <= s2_mx_q;
      s3_sb_q.mag_y    <= s2_my_q;
      s3_sb_q.rsum     <= RsumW'(s2_wa_q) + RsumW'(s2_wb_q);
      s3_sqx_q         <= SqW'(s2_mx_q) * SqW'(s2_mx_q);
      s3_sqy_q         <= SqW'(s2_my_q) * SqW'(s2_my_q);

      s4_sb_q <= s3_sb_q;
      s4_n_q  <= s3_sqx_q + s3_sqy_q;
    end
  end

  assign vld_o = vld_q[3];
  assign n_o   = s4_n_q;
  assign sb_o  = s4_sb_q;

endmodule

// File: src/cop_sqrt.sv
// ----------------------------------------------------------------------------
// cop_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cop_sqrt #(
  parameter int unsigned IN_W = cop_pkg::SqW,
  parameter int unsigned SB_W = $bits(cop_pkg::cop_sq_sb_t)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [IN_W-1:0]     n_i,
  input  logic [SB_W-1:0]     sb_i,
  output logic                vld_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SB_W-1:0]     sb_o
);
  localparam int unsigned RtW = IN_W / 2;
  localparam int unsigned RmW = RtW + 2;

  logic [RtW-1:0]  vld_q;
  logic [RmW-1:0]  rem_q  [RtW];
  logic [RtW-1:0]  root_q [RtW];
  logic [IN_W-1:0] rad_q  [RtW];
  logic [SB_W-1:0] sb_q   [RtW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RtW-2:0], vld_i};
    end
  end

  for (genvar g = 0; g < RtW; g++) begin : g_stage
    logic [RmW-1:0]  rem_in, rem_sh, trial;
    logic [RtW-1:0]  root_in;
    logic [IN_W-1:0] rad_in;
    logic [SB_W-1:0] sb_in;
    logic            ge;

    if (g == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = n_i;
      assign sb_in   = sb_i;
    end else begin : g_body
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign sb_in   = sb_q[g-1];
    end

    assign rem_sh = {rem_in[RmW-3:0], rad_in[IN_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= ge ? rem_sh - trial : rem_sh;
        root_q[g] <= {root_in[RtW-2:0], ge};
        rad_q[g]  <= {rad_in[IN_W-3:0], 2'b00};
        sb_q[g]   <= sb_in;
      end
    end
  end

  assign vld_o  = vld_q[RtW-1];
  assign root_o = root_q[RtW-1];
  assign sb_o   = sb_q[RtW-1];

endmodule

// File: src/cop_div.sv
// ----------------------------------------------------------------------------
// cop_div
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit
// per stage. The quotient must fit QUO_W bits.
// ----------------------------------------------------------------------------
module cop_div #(
  parameter int unsigned DEN_W = cop_pkg::DistW,
  parameter int unsigned QUO_W = cop_pkg::QuoW,
  parameter int unsigned SB_W  = $bits(cop_pkg::cop_dv_sb_t)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic [DEN_W+QUO_W-1:0]   num_x_i,
  input  logic [DEN_W+QUO_W-1:0]   num_y_i,
  input  logic [DEN_W-1:0]         den_i,
  input  logic [SB_W-1:0]          sb_i,
  output logic                     vld_o,
  output logic [QUO_W-1:0]         quo_x_o,
  output logic [QUO_W-1:0]         quo_y_o,
  output logic [SB_W-1:0]          sb_o
);
  localparam int unsigned NumW = DEN_W + QUO_W;

  logic [QUO_W-1:0] vld_q;
  logic [DEN_W-1:0] remx_q [QUO_W];
  logic [DEN_W-1:0] remy_q [QUO_W];
  logic [QUO_W-1:0] nbx_q  [QUO_W];
  logic [QUO_W-1:0] nby_q  [QUO_W];
  logic [QUO_W-1:0] qx_q   [QUO_W];
  logic [QUO_W-1:0] qy_q   [QUO_W];
  logic [DEN_W-1:0] den_q  [QUO_W];
  logic [SB_W-1:0]  sb_q   [QUO_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QUO_W-2:0], vld_i};
    end
  end

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    logic [DEN_W-1:0] rx_in, ry_in, den_in;
    logic [QUO_W-1:0] nx_in, ny_in, qx_in, qy_in;
    logic [SB_W-1:0]  sb_in;
    logic [DEN_W:0]   rx_sh, ry_sh, den_ext;
    logic             gex, gey;

    if (g == 0) begin : g_head
      assign rx_in  = num_x_i[NumW-1 -: DEN_W];
      assign ry_in  = num_y_i[NumW-1 -: DEN_W];
      assign nx_in  = num_x_i[QUO_W-1:0];
      assign ny_in  = num_y_i[QUO_W-1:0];
      assign qx_in  = '0;
      assign qy_in  = '0;
      assign den_in = den_i;
      assign sb_in  = sb_i;
    end else begin : g_body
      assign rx_in  = remx_q[g-1];
      assign ry_in  = remy_q[g-1];
      assign nx_in  = nbx_q[g-1];
      assign ny_in  = nby_q[g-1];
      assign qx_in  = qx_q[g-1];
      assign qy_in  = qy_q[g-1];
      assign den_in = den_q[g-1];
      assign sb_in  = sb_q[g-1];
    end

    assign den_ext = {1'b0, den_in};
    assign rx_sh   = {rx_in, nx_in[QUO_W-1]};
    assign ry_sh   = {ry_in, ny_in[QUO_W-1]};
    assign gex     = (rx_sh >= den_ext);
    assign gey     = (ry_sh >= den_ext);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        remx_q[g] <= DEN_W'(gex ? rx_sh - den_ext : rx_sh);
        remy_q[g] <= DEN_W'(gey ? ry_sh - den_ext : ry_sh);
        nbx_q[g]  <= {nx_in[QUO_W-2:0], 1'b0};
        nby_q[g]  <= {ny_in[QUO_W-2:0], 1'b0};
        qx_q[g]   <= {qx_in[QUO_W-2:0], gex};
        qy_q[g]   <= {qy_in[QUO_W-2:0], gey};
        den_q[g]  <= den_in;
        sb_q[g]   <= sb_in;
      end
    end
  end

  assign vld_o   = vld_q[QUO_W-1];
  assign quo_x_o = qx_q[QUO_W-1];
  assign quo_y_o = qy_q[QUO_W-1];
  assign sb_o    = sb_q[QUO_W-1];

endmodule

// File: src/circle_overlap_push_out.sv
// ----------------------------------------------------------------------------
// circle_overlap_push_out
// Circle-circle hit test with push-out of circle B along the A-to-B line.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+--------------------------------
//   in      | input     | in_valid_i / in_stall_o | opcode, centres, radii, scales
//   out     | output    | out_valid_o/out_stall_i | collided, new_b_x, new_b_y
//
// One word enters per cycle unless a result is stalled at the output. Each
// word passes 82 registers, the first loaded at the accepting edge:
// the input register, 4 front stages, 33 square-root stages (one root bit
// each), 3 stages for the hit test and overlap products, 40 divider stages
// (one quotient bit each) and the saturating output register.
// Reset clears only the valid bits; payload registers are not reset.
// A stalled result freezes the whole pipeline, output register included;
// any bubble ahead of it is not squeezed out.
module circle_overlap_push_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic signed [cop_pkg::CoordW-1:0]  a_x_i,
  input  logic signed [cop_pkg::CoordW-1:0]  a_y_i,
  input  logic signed [cop_pkg::CoordW-1:0]  b_x_i,
  input  logic signed [cop_pkg::CoordW-1:0]  b_y_i,
  input  logic        [cop_pkg::RadW-1:0]    a_radius_i,
  input  logic        [cop_pkg::RadW-1:0]    b_radius_i,
  input  logic        [cop_pkg::ScaleW-1:0]  a_scale_x_i,
  input  logic        [cop_pkg::ScaleW-1:0]  a_scale_y_i,
  input  logic        [cop_pkg::ScaleW-1:0]  b_scale_x_i,
  input  logic        [cop_pkg::ScaleW-1:0]  b_scale_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               collided_o,
  output logic signed [cop_pkg::CoordW-1:0]  new_b_x_o,
  output logic signed [cop_pkg::CoordW-1:0]  new_b_y_o
);
  import cop_pkg::*;

  localparam int unsigned SumW = CoordW + QuoW + 2;

  // Advance everything unless a finished word sits stalled at the output.
  logic adv;
  logic out_valid_q;
  logic col_q;
  logic signed [CoordW-1:0] nbx_q, nby_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // Input register
  logic    in_vld_q;
  cop_in_t in_q, in_word;

  assign in_word = '{opcode: opcode_i, a_x: a_x_i, a_y: a_y_i, b_x: b_x_i, b_y: b_y_i,
                     a_radius: a_radius_i, b_radius: b_radius_i,
                     a_scale_x: a_scale_x_i, a_scale_y: a_scale_y_i,
                     b_scale_x: b_scale_x_i, b_scale_y: b_scale_y_i};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_word;
    end
  end

  // Front end: deltas, world radii, squared distance
  logic           fr_vld;
  logic [SqW-1:0] fr_n;
  cop_sq_sb_t     fr_sb;

  cop_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (in_vld_q),
    .word_i (in_q),
    .vld_o  (fr_vld),
    .n_o    (fr_n),
    .sb_o   (fr_sb)
  );

  // Distance = floor(sqrt(dx^2 + dy^2))
  logic             sq_vld;
  logic [DistW-1:0] sq_dist;
  cop_sq_sb_t       sq_sb;

  cop_sqrt #(
    .IN_W (SqW),
    .SB_W ($bits(cop_sq_sb_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (fr_vld),
    .n_i    (fr_n),
    .sb_i   (fr_sb),
    .vld_o  (sq_vld),
    .root_o (sq_dist),
    .sb_o   (sq_sb)
  );

  // P1: hit test and overlap. Push only with a direction (nonzero distance).
  logic             p1_vld_q;
  cop_dv_sb_t       p1_sb_q;
  logic [RsumW-1:0] p1_ovl_q;
  logic [DistW-1:0] p1_dist_q;
  logic [DiffW-1:0] p1_mx_q, p1_my_q;
  logic             hit;

  assign hit = RsumW'(sq_dist) < sq_sb.rsum;

  // P2: overlap split into halves so each partial product is 33 by 20 bits.
  logic             p2_vld_q;
  cop_dv_sb_t       p2_sb_q;
  logic [DistW-1:0] p2_dist_q;
  logic [PartW-1:0] p2_xl_q, p2_xh_q, p2_yl_q, p2_yh_q;

  // P3: recombine the partial products into the dividend.
  logic             p3_vld_q;
  cop_dv_sb_t       p3_sb_q;
  logic [DistW-1:0] p3_dist_q;
  logic [NumW-1:0]  p3_nx_q, p3_ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= in_valid_i;
      p1_vld_q <= sq_vld;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_sb_q.hit   <= hit;
      p1_sb_q.push  <= sq_sb.push_req && hit && (sq_dist != '0);
      p1_sb_q.b_x   <= sq_sb.b_x;
      p1_sb_q.b_y   <= sq_sb.b_y;
      p1_sb_q.neg_x <= sq_sb.neg_x;
      p1_sb_q.neg_y <= sq_sb.neg_y;
      p1_ovl_q      <= sq_sb.rsum - RsumW'(sq_dist);
      p1_dist_q     <= sq_dist;
      p1_mx_q       <= sq_sb.mag_x;
      p1_my_q       <= sq_sb.mag_y;

      p2_sb_q   <= p1_sb_q;
      p2_dist_q <= p1_dist_q;
      p2_xl_q   <= PartW'(p1_mx_q) * PartW'(p1_ovl_q[OvlLoW-1:0]);
      p2_xh_q   <= PartW'(p1_mx_q) * PartW'(p1_ovl_q[RsumW-1:OvlLoW]);
      p2_yl_q   <= PartW'(p1_my_q) * PartW'(p1_ovl_q[OvlLoW-1:0]);
      p2_yh_q   <= PartW'(p1_my_q) * PartW'(p1_ovl_q[RsumW-1:OvlLoW]);

      p3_sb_q   <= p2_sb_q;
      p3_dist_q <= p2_dist_q;
      p3_nx_q   <= NumW'(p2_xl_q) + (NumW'(p2_xh_q) << OvlLoW);
      p3_ny_q   <= NumW'(p2_yl_q) + (NumW'(p2_yh_q) << OvlLoW);
    end
  end

  // Push magnitude = |d| * overlap / distance, truncated
  logic            dv_vld;
  logic [QuoW-1:0] dv_qx, dv_qy;
  cop_dv_sb_t      dv_sb;

  cop_div #(
    .DEN_W (DistW),
    .QUO_W (QuoW),
    .SB_W  ($bits(cop_dv_sb_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (p3_vld_q),
    .num_x_i (p3_nx_q),
    .num_y_i (p3_ny_q),
    .den_i   (p3_dist_q),
    .sb_i    (p3_sb_q),
    .vld_o   (dv_vld),
    .quo_x_o (dv_qx),
    .quo_y_o (dv_qy),
    .sb_o    (dv_sb)
  );

  // Add signed push to B and clamp to the 32-bit range.
  function automatic logic signed [CoordW-1:0] push_sat(
    input logic signed [CoordW-1:0] b,
    input logic                     neg,
    input logic [QuoW-1:0]          q
  );
    logic signed [SumW-1:0] bw, qw, v;
    bw = SumW'(b);
    qw = $signed(SumW'(q));
    v  = neg ? bw - qw : bw + qw;
    if (v[SumW-1:CoordW-1] == '0 || v[SumW-1:CoordW-1] == '1) begin
      push_sat = v[CoordW-1:0];
    end else if (v[SumW-1]) begin
      push_sat = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      push_sat = {1'b0, {(CoordW-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      col_q <= dv_sb.hit;
      nbx_q <= dv_sb.push ? push_sat(dv_sb.b_x, dv_sb.neg_x, dv_qx) : dv_sb.b_x;
      nby_q <= dv_sb.push ? push_sat(dv_sb.b_y, dv_sb.neg_y, dv_qy) : dv_sb.b_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign collided_o  = col_q;
  assign new_b_x_o   = nbx_q;
  assign new_b_y_o   = nby_q;

  // Push only on a hit.
  a_push_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_vld_q && p1_sb_q.push |-> p1_sb_q.hit)
    else $error("push without hit");

  // Push never with zero distance.
  a_push_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_vld_q && p1_sb_q.push |-> p1_dist_q != '0)
    else $error("push with zero distance");

  // Input stalls only behind a waiting result.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // Frozen pipeline keeps its inner valid bits.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(p1_vld_q) && $stable(p3_vld_q))
    else $error("pipeline moved while stalled");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams circle pairs through the push-out pipeline with random gaps on
// both channels and checks every result word against an internal predictor
// of the hit test and push-out arithmetic.
// ----------------------------------------------------------------------------
module testbench;
  import cop_pkg::*;

  localparam int unsigned IdleLimit = 5000;  // cycles with no word moving
  localparam int unsigned NumRandom = 800;
  localparam int unsigned Drain     = 100;   // idle cycles after the last result

  typedef struct {
    logic                     collided;
    logic signed [CoordW-1:0] new_b_x;
    logic signed [CoordW-1:0] new_b_y;
  } push_result_t;

  // Holds the predicted results in order and compares the arriving words.
  class push_scoreboard;
    push_result_t pending[$];
    int errors = 0;
    int hits = 0;
    int pushes = 0;

    function automatic bit [127:0] root_floor(bit [127:0] n);
      bit [127:0] res;
      bit [127:0] cand;
      res = 0;
      for (int i = 33; i >= 0; i--) begin
        cand = res | (128'd1 << i);
        if (cand * cand <= n) res = cand;
      end
      return res;
    endfunction

    function automatic logic signed [CoordW-1:0] shift_axis(longint b, longint d,
                                                           bit [127:0] ovl,
                                                           bit [127:0] span);
      bit [127:0] mag;
      bit [127:0] q;
      longint v;
      mag = (d < 0) ? 128'(-d) : 128'(d);
      q = (mag * ovl) / span;
      v = (d < 0) ? b - longint'(q[63:0]) : b + longint'(q[63:0]);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[CoordW-1:0];
    endfunction

    function void note_pair(cop_in_t w);
      push_result_t r;
      bit [127:0] rsum;
      bit [127:0] span;
      bit [127:0] mx;
      bit [127:0] my;
      longint dx;
      longint dy;
      rsum = ((128'(w.a_radius) * (128'(w.a_scale_x) + 128'(w.a_scale_y))) >> MeanSh)
           + ((128'(w.b_radius) * (128'(w.b_scale_x) + 128'(w.b_scale_y))) >> MeanSh);
      dx = longint'($signed(w.b_x)) - longint'($signed(w.a_x));
      dy = longint'($signed(w.b_y)) - longint'($signed(w.a_y));
      mx = (dx < 0) ? 128'(-dx) : 128'(dx);
      my = (dy < 0) ? 128'(-dy) : 128'(dy);
      span = root_floor(mx * mx + my * my);
      r.collided = span < rsum;
      r.new_b_x = w.b_x;
      r.new_b_y = w.b_y;
      if (r.collided) hits++;
      // Coincident centres give no direction: B stays put.
      if (w.opcode && r.collided && span != 0) begin
        pushes++;
        r.new_b_x = shift_axis($signed(w.b_x), dx, rsum - span, span);
        r.new_b_y = shift_axis($signed(w.b_y), dy, rsum - span, span);
      end
      pending.insert(pending.size(), r);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(push_result_t got);
      push_result_t exp;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      exp = pending.pop_front();
      if (got.collided !== exp.collided)
        report($sformatf("collided %0b, expected %0b", got.collided, exp.collided));
      if (got.new_b_x !== exp.new_b_x)
        report($sformatf("new_b_x %0d, expected %0d", got.new_b_x, exp.new_b_x));
      if (got.new_b_y !== exp.new_b_y)
        report($sformatf("new_b_y %0d, expected %0d", got.new_b_y, exp.new_b_y));
    endtask
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     opcode_i = 1'b0;
  logic signed [CoordW-1:0] a_x_i = '0;
  logic signed [CoordW-1:0] a_y_i = '0;
  logic signed [CoordW-1:0] b_x_i = '0;
  logic signed [CoordW-1:0] b_y_i = '0;
  logic        [RadW-1:0]   a_radius_i = '0;
  logic        [RadW-1:0]   b_radius_i = '0;
  logic        [ScaleW-1:0] a_scale_x_i = '0;
  logic        [ScaleW-1:0] a_scale_y_i = '0;
  logic        [ScaleW-1:0] b_scale_x_i = '0;
  logic        [ScaleW-1:0] b_scale_y_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b1;
  logic                     collided_o;
  logic signed [CoordW-1:0] new_b_x_o;
  logic signed [CoordW-1:0] new_b_y_o;

  push_scoreboard sb = new();
  bit     calm = 1'b0;     // phase with no idling on either side
  int     sent = 0;
  int     idle_cycles = 0;
  bit     moved = 1'b0;

  always #5 clk_i = ~clk_i;

  circle_overlap_push_out dut (.*);

  // Watchdog: count cycles in which no word moves on either channel.
  always @(posedge clk_i) begin
    if (moved) idle_cycles <= 0;
    else       idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Sample the output channel at the falling edge, where every signal is
  // settled; a word seen valid and unstalled here is taken at the next rise.
  always @(negedge clk_i) begin
    push_result_t got;
    moved = (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.collided = collided_o;
      got.new_b_x = new_b_x_o;
      got.new_b_y = new_b_y_o;
      sb.check_result(got);
    end
  end

  // Drive the output stall: hold it for a random number of cycles per word,
  // then release it until the word is taken.
  initial begin
    int n;
    bit taken;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      n = calm ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        taken = out_valid_o;
        @(posedge clk_i);
      end while (!taken);
    end
  end

  // Send one word after a random gap and wait for it to be accepted.
  task automatic send_pair(cop_in_t w);
    int gap;
    bit taken;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= w.opcode;
    a_x_i       <= w.a_x;
    a_y_i       <= w.a_y;
    b_x_i       <= w.b_x;
    b_y_i       <= w.b_y;
    a_radius_i  <= w.a_radius;
    b_radius_i  <= w.b_radius;
    a_scale_x_i <= w.a_scale_x;
    a_scale_y_i <= w.a_scale_y;
    b_scale_x_i <= w.b_scale_x;
    b_scale_y_i <= w.b_scale_y;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    sb.note_pair(w);
    sent++;
  endtask

  function automatic cop_in_t make_pair(bit op, int ax, int ay, int bx, int by,
                                        int unsigned ra, int unsigned rb,
                                        int unsigned sa, int unsigned sb_s);
    cop_in_t w;
    w.opcode = op;
    w.a_x = ax;
    w.a_y = ay;
    w.b_x = bx;
    w.b_y = by;
    w.a_radius = ra[RadW-1:0];
    w.b_radius = rb[RadW-1:0];
    w.a_scale_x = sa[ScaleW-1:0];
    w.a_scale_y = sa[ScaleW-1:0];
    w.b_scale_x = sb_s[ScaleW-1:0];
    w.b_scale_y = sb_s[ScaleW-1:0];
    return w;
  endfunction

  // Draw a random pair: mostly circles close enough to touch, with unit-ish
  // scales, plus fully random words that exercise every field bit.
  function automatic cop_in_t random_pair();
    cop_in_t w;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    w.opcode = $urandom_range(0, 3) != 0;
    if (kind < 2) begin
      w.a_x = $urandom(); w.a_y = $urandom();
      w.b_x = $urandom(); w.b_y = $urandom();
      w.a_radius = RadW'($urandom()); w.b_radius = RadW'($urandom());
      w.a_scale_x = ScaleW'($urandom()); w.a_scale_y = ScaleW'($urandom());
      w.b_scale_x = ScaleW'($urandom()); w.b_scale_y = ScaleW'($urandom());
    end else begin
      w.a_x = $signed($urandom()) >>> $urandom_range(1, 12);
      w.a_y = $signed($urandom()) >>> $urandom_range(1, 12);
      w.b_x = w.a_x + ($signed($urandom()) >>> $urandom_range(8, 14));
      w.b_y = w.a_y + ($signed($urandom()) >>> $urandom_range(8, 14));
      w.a_radius = RadW'($urandom() >> $urandom_range(10, 16));
      // Leave B as a point now and then.
      w.b_radius = (kind == 9) ? '0 : RadW'($urandom() >> $urandom_range(10, 16));
      w.a_scale_x = ScaleW'($urandom_range(64, 1024));
      w.a_scale_y = ScaleW'($urandom_range(64, 1024));
      w.b_scale_x = ScaleW'($urandom_range(64, 1024));
      w.b_scale_y = ScaleW'($urandom_range(64, 1024));
    end
    return w;
  endfunction

  initial begin
    cop_in_t w;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: all zero, test-only hit, point test, coincident
    // centres, no hit in push mode, full scale and saturating pushes.
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(1, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(0, 0, 0, 65536, 0, 131072, 131072, 256, 256));
    send_pair(make_pair(1, 0, 0, 65536, 0, 131072, 131072, 256, 256));
    send_pair(make_pair(1, 0, 0, 30000, 40000, 131072, 0, 256, 256));
    send_pair(make_pair(0, 0, 0, 30000, 40000, 131072, 0, 256, 256));
    send_pair(make_pair(1, 100, -100, 100, -100, 65536, 65536, 256, 256));
    send_pair(make_pair(1, 0, 0, 10000000, 0, 65536, 65536, 256, 256));
    send_pair(make_pair(1, 0, 0, -65536, -65536, 65536, 65536, 256, 256));
    send_pair(make_pair(1, 0, 0, 1, 0, 32'h7fffffff, 32'h7fffffff, 65535, 65535));
    send_pair(make_pair(1, 0, 0, -1, -1, 32'h7fffffff, 32'h7fffffff, 65535, 65535));
    send_pair(make_pair(1, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                        32'h7fffffff, 32'h7fffffff, 65535, 65535));
    send_pair(make_pair(1, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                        32'h7fffffff, 32'h7fffffff, 65535, 65535));
    send_pair(make_pair(0, 32'sh80000000, 0, 32'sh7fffffff, 0, 32'h7fffffff, 0,
                        65535, 0));
    send_pair(make_pair(1, 5, 5, 6, 5, 1, 1, 256, 256));
    send_pair(make_pair(1, 0, 0, 2, 0, 1, 1, 256, 256));

    // Random words in phases, alternating idling and back-to-back traffic.
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 100 == 0) calm = (i / 100) % 3 == 2;
      send_pair(random_pair());
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);

    $display("sent %0d circle pairs, %0d hits, %0d pushed out", sent, sb.hits, sb.pushes);
    $display("%0d mismatches, %0d results left over", sb.errors, sb.pending.size());
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
